// ----- design/rv32i_core_machine_mode_assert.svh -----
// Assertion macros used by the core's top-level RTL file.
`ifndef RV32I_CORE_MACHINE_MODE_ASSERT_SVH
`define RV32I_CORE_MACHINE_MODE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RVCM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rvcm assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define RVCM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rvcm assertion failed");

`endif

// ----- design/rvcm_pkg.sv -----
`default_nettype none
package rvcm_pkg;

  localparam int unsigned FAST_IRQ_LINES = 16;

  // Item kinds on the input stream.
  localparam logic [1:0] OP_INSTR  = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_IRQ    = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEBUG_CONTROL = 2'd0;
  localparam logic [1:0] CFG_DEBUG_HALTED  = 2'd1;
  localparam logic [1:0] CFG_RESET_PC      = 2'd2;

  // Major opcodes.
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_SYSTEM = 7'b1110011;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;

  // CSR addresses.
  localparam logic [11:0] ADDR_MSTATUS  = 12'h300;
  localparam logic [11:0] ADDR_MISA     = 12'h301;
  localparam logic [11:0] ADDR_MIE      = 12'h304;
  localparam logic [11:0] ADDR_MTVEC    = 12'h305;
  localparam logic [11:0] ADDR_MSCRATCH = 12'h340;
  localparam logic [11:0] ADDR_MEPC     = 12'h341;
  localparam logic [11:0] ADDR_MCAUSE   = 12'h342;
  localparam logic [11:0] ADDR_MTVAL    = 12'h343;
  localparam logic [11:0] ADDR_MIP      = 12'h344;

  // Slots of the CSR array.
  localparam int unsigned NUM_CSRS = 9;
  localparam logic [3:0] SLOT_MSTATUS  = 4'd0;
  localparam logic [3:0] SLOT_MISA     = 4'd1;
  localparam logic [3:0] SLOT_MIE      = 4'd2;
  localparam logic [3:0] SLOT_MTVEC    = 4'd3;
  localparam logic [3:0] SLOT_MSCRATCH = 4'd4;
  localparam logic [3:0] SLOT_MEPC     = 4'd5;
  localparam logic [3:0] SLOT_MCAUSE   = 4'd6;
  localparam logic [3:0] SLOT_MTVAL    = 4'd7;
  localparam logic [3:0] SLOT_MIP      = 4'd8;

  // Exception cause codes.
  localparam logic [31:0] CAUSE_FETCH   = 32'd1;
  localparam logic [31:0] CAUSE_ILLEGAL = 32'd2;
  localparam logic [31:0] CAUSE_BREAK   = 32'd3;
  localparam logic [31:0] CAUSE_UCALL   = 32'd8;
  localparam logic [31:0] CAUSE_MCALL   = 32'd11;

  // Halt reasons.
  localparam logic [1:0] HALT_EBREAK = 2'd0;
  localparam logic [1:0] HALT_VCATCH = 2'd1;
  localparam logic [1:0] HALT_STEP   = 2'd2;

  localparam logic [1:0] MODE_USER    = 2'd0;
  localparam logic [1:0] MODE_MACHINE = 2'd3;

  typedef struct packed {
    logic        we;
    logic [4:0]  addr;
    logic [31:0] data;
  } rf_wr_t;

endpackage
`default_nettype wire

// ----- design/rvcm_regfile.sv -----
`default_nettype none
module rvcm_regfile
  import rvcm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        rd_en_i,
  input  wire logic [4:0]  raddr_a_i,
  input  wire logic [4:0]  raddr_b_i,
  output logic      [31:0] rdata_a_o,
  output logic      [31:0] rdata_b_o,
  input  wire rf_wr_t      wr_i
);

  logic [31:0] mem_q [32];
  logic [31:0] valid_q;
  logic [31:0] rdata_a_q, rdata_b_q;
  logic        rvalid_a_q, rvalid_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  // Entries never written since reset read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rvalid_a_q <= 1'b0;
      rvalid_b_q <= 1'b0;
    end else begin
      if (wr_i.we) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rvalid_a_q <= valid_q[raddr_a_i];
        rvalid_b_q <= valid_q[raddr_b_i];
      end
    end
  end

  assign rdata_a_o = rvalid_a_q ? rdata_a_q : '0;
  assign rdata_b_o = rvalid_b_q ? rdata_b_q : '0;

endmodule
`default_nettype wire

// ----- design/rv32i_core_machine_mode.sv -----
`default_nettype none
`include "rv32i_core_machine_mode_assert.svh"
// RV32I machine-mode core driven by a stream of items: fetched instructions, returned load
// data and fast interrupt raises. It accepts one item per cycle unless the output stalls
// and delivers its result from an output register fed by the execute stage, so the
// throughput is one item per cycle; a load takes two items (the instruction and its data).
// The register file is a synchronous memory read at acceptance from the instruction's rs1
// and rs2 fields, with a bypass for the write made by the item executing at the same edge;
// the single execute stage behind it sets the rate. The register file needs no clearing
// pass. Configuration writes are taken only while no item waits in the execute stage.
module rv32i_core_machine_mode
  import rvcm_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // instruction[31:0], fetch_fault[32], load_data[64:33], irq_index[68:65], zero pad
  input  wire logic [71:0]   s_axis_tdata,
  // op[1:0]
  input  wire logic [1:0]    s_axis_tuser,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // next_pc[31:0], mem_valid[32], mem_write[33], mem_addr[65:34], mem_size[67:66],
  // store_data[99:68], trap_taken[100], trap_cause[105:101], trap_interrupt[106],
  // halt_request[107], halt_reason[109:108], zero pad
  output logic      [111:0]  m_axis_tdata,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [1:0]    cfg_index_i,
  input  wire logic [31:0]   cfg_data_i
);

  logic s_accept, s1_fire;

  logic        s1_valid_q;
  logic [1:0]  s1_op_q;
  logic [31:0] s1_ins_q;
  logic        s1_fault_q;
  logic [31:0] s1_ld_q;
  logic [3:0]  s1_irq_q;
  logic        fwd_a_q, fwd_b_q;
  logic [31:0] fwd_data_q;

  logic [31:0] pc_q, pc_n;
  logic [1:0]  mode_q, mode_n;
  logic [31:0] csr_q [NUM_CSRS];
  logic [31:0] csr_n [NUM_CSRS];
  logic        trap_pend_q, trap_pend_n;
  logic        ld_valid_q, ld_valid_n;
  logic [4:0]  ld_rd_q, ld_rd_n;
  logic [2:0]  ld_f3_q, ld_f3_n;
  logic [2:0]  dbg_ctrl_q;
  logic        dbg_halt_q;

  logic        out_valid_q;
  logic [111:0] out_data_q, out_data_d;

  rf_wr_t      rf_wr, rf_wr_n;
  logic [31:0] rdata_a, rdata_b, op_a, op_b;

  rvcm_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (s_accept),
    .raddr_a_i (s_axis_tdata[19:15]),
    .raddr_b_i (s_axis_tdata[24:20]),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b),
    .wr_i      (rf_wr)
  );

  assign s1_fire       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_fire;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = !s1_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign op_a = fwd_a_q ? fwd_data_q : rdata_a;
  assign op_b = fwd_b_q ? fwd_data_q : rdata_b;

  assign rf_wr.we   = rf_wr_n.we && s1_fire;
  assign rf_wr.addr = rf_wr_n.addr;
  assign rf_wr.data = rf_wr_n.data;

  function automatic logic [4:0] csr_slot(input logic [11:0] addr);
    logic [4:0] r;
    unique case (addr)
      ADDR_MSTATUS:  r = {1'b1, SLOT_MSTATUS};
      ADDR_MISA:     r = {1'b1, SLOT_MISA};
      ADDR_MIE:      r = {1'b1, SLOT_MIE};
      ADDR_MTVEC:    r = {1'b1, SLOT_MTVEC};
      ADDR_MSCRATCH: r = {1'b1, SLOT_MSCRATCH};
      ADDR_MEPC:     r = {1'b1, SLOT_MEPC};
      ADDR_MCAUSE:   r = {1'b1, SLOT_MCAUSE};
      ADDR_MTVAL:    r = {1'b1, SLOT_MTVAL};
      ADDR_MIP:      r = {1'b1, SLOT_MIP};
      default:       r = 5'd0;
    endcase
    return r;
  endfunction

  always_comb begin
    logic [31:0] ins, npc, ii, si, bi, ji, v, src, old, nv, s, tval, ecode;
    logic [6:0]  opc;
    logic [4:0]  rd, rs1, rs2, sh, slot, bitn;
    logic [2:0]  f3;
    logic        t, exc, stop, hreq, found, o_mvalid, o_mwrite, o_trap, o_intr;
    logic [1:0]  hreason, o_msize;
    logic [31:0] o_maddr, o_sdata;
    logic [4:0]  o_cause;
    logic [3:0]  sel;

    pc_n        = pc_q;
    mode_n      = mode_q;
    csr_n       = csr_q;
    trap_pend_n = trap_pend_q;
    ld_valid_n  = ld_valid_q;
    ld_rd_n     = ld_rd_q;
    ld_f3_n     = ld_f3_q;
    rf_wr_n     = '0;
    o_mvalid = 1'b0; o_mwrite = 1'b0; o_maddr = '0; o_msize = '0; o_sdata = '0;
    o_trap = 1'b0; o_cause = '0; o_intr = 1'b0; hreq = 1'b0; hreason = '0;

    ins = s1_ins_q;
    opc = ins[6:0];
    rd  = ins[11:7];
    f3  = ins[14:12];
    rs1 = ins[19:15];
    rs2 = ins[24:20];
    ii  = {{20{ins[31]}}, ins[31:20]};
    si  = {{20{ins[31]}}, ins[31:25], ins[11:7]};
    bi  = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
    ji  = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
    npc = pc_q + 32'd4;
    v = '0; src = '0; old = '0; nv = '0; s = '0; sh = '0; slot = '0; bitn = '0;
    t = 1'b0; exc = 1'b0; stop = 1'b0; ecode = '0; tval = '0;
    found = 1'b0; sel = '0;

    if (!dbg_halt_q) begin
      if (s1_op_q == OP_INSTR && !ld_valid_q) begin
        if (s1_fault_q) begin
          exc = 1'b1; stop = 1'b1; ecode = CAUSE_FETCH; tval = pc_q;
        end else begin
          unique case (opc)
            OPC_LUI: begin
              rf_wr_n = '{we: rd != 5'd0, addr: rd, data: {ins[31:12], 12'd0}};
            end
            OPC_AUIPC: begin
              rf_wr_n = '{we: rd != 5'd0, addr: rd, data: pc_q + {ins[31:12], 12'd0}};
            end
            OPC_OPIMM, OPC_OP: begin
              if (opc == OPC_OP) ii = op_b;
              sh = ii[4:0];
              unique case (f3)
                3'd0: v = (opc == OPC_OP && ins[30]) ? op_a - op_b : op_a + ii;
                3'd1: v = op_a << sh;
                3'd2: v = {31'd0, $signed(op_a) < $signed(ii)};
                3'd3: v = {31'd0, op_a < ii};
                3'd4: v = op_a ^ ii;
                3'd5: v = ins[30] ? 32'($signed(op_a) >>> sh) : op_a >> sh;
                3'd6: v = op_a | ii;
                default: v = op_a & ii;
              endcase
              rf_wr_n = '{we: rd != 5'd0, addr: rd, data: v};
            end
            OPC_SYSTEM: begin
              if (f3 == 3'd0) begin
                npc = pc_q;
                if (rs2 == 5'd0) begin
                  if (mode_q == MODE_MACHINE) begin
                    exc = 1'b1; ecode = CAUSE_MCALL;
                  end else if (mode_q == MODE_USER) begin
                    exc = 1'b1; ecode = CAUSE_UCALL;
                  end else begin
                    exc = 1'b1; stop = 1'b1; ecode = CAUSE_ILLEGAL; tval = ins;
                  end
                end else if (rs2 == 5'd1) begin
                  if (dbg_ctrl_q[0]) begin
                    hreq = 1'b1; hreason = HALT_EBREAK;
                  end else begin
                    exc = 1'b1; stop = 1'b1; ecode = CAUSE_BREAK;
                  end
                end else if (rs2 == 5'd2 && mode_q == MODE_MACHINE) begin
                  s = csr_q[SLOT_MSTATUS];
                  mode_n = s[12:11];
                  s[12:11] = 2'd0;
                  s[3] = s[7];
                  s[7] = 1'b1;
                  csr_n[SLOT_MSTATUS] = s;
                  npc = csr_q[SLOT_MEPC];
                end else begin
                  exc = 1'b1; stop = 1'b1; ecode = CAUSE_ILLEGAL; tval = ins;
                end
              end else if (f3 == 3'd4) begin
                exc = 1'b1; stop = 1'b1; ecode = CAUSE_ILLEGAL; tval = ins;
              end else begin
                src  = f3[2] ? {27'd0, rs1} : op_a;
                slot = csr_slot(ins[31:20]);
                old  = slot[4] ? csr_q[slot[3:0]] : '0;
                unique case (f3[1:0])
                  2'd1:    nv = src;
                  2'd2:    nv = old | src;
                  default: nv = old & ~src;
                endcase
                if (slot[4]) csr_n[slot[3:0]] = nv;
                rf_wr_n = '{we: rd != 5'd0, addr: rd, data: old};
              end
            end
            OPC_LOAD: begin
              if (f3 == 3'd3 || f3 > 3'd5) begin
                exc = 1'b1; stop = 1'b1; ecode = CAUSE_ILLEGAL; tval = ins;
              end else begin
                o_mvalid = 1'b1; o_maddr = op_a + ii; o_msize = f3[1:0];
                ld_valid_n = 1'b1; ld_rd_n = rd; ld_f3_n = f3;
                pc_n = npc;
                stop = 1'b1;
              end
            end
            OPC_STORE: begin
              if (f3 > 3'd2) begin
                exc = 1'b1; stop = 1'b1; ecode = CAUSE_ILLEGAL; tval = ins;
              end else begin
                o_mvalid = 1'b1; o_mwrite = 1'b1; o_maddr = op_a + si;
                o_msize = f3[1:0]; o_sdata = op_b;
              end
            end
            OPC_JAL: begin
              rf_wr_n = '{we: rd != 5'd0, addr: rd, data: pc_q + 32'd4};
              npc = pc_q + ji;
            end
            OPC_JALR: begin
              npc = (op_a + ii) & ~32'd1;
              rf_wr_n = '{we: rd != 5'd0, addr: rd, data: pc_q + 32'd4};
            end
            OPC_BRANCH: begin
              unique case (f3)
                3'd0: t = op_a == op_b;
                3'd1: t = op_a != op_b;
                3'd4: t = $signed(op_a) < $signed(op_b);
                3'd5: t = !($signed(op_a) < $signed(op_b));
                3'd6: t = op_a < op_b;
                3'd7: t = op_a >= op_b;
                default: begin
                  exc = 1'b1; stop = 1'b1; ecode = CAUSE_ILLEGAL; tval = ins;
                end
              endcase
              if (t) npc = pc_q + bi;
            end
            default: begin
              exc = 1'b1; stop = 1'b1; ecode = CAUSE_ILLEGAL; tval = ins;
            end
          endcase
        end
        if (exc) begin
          if (dbg_ctrl_q[2] && !hreq) begin
            hreq = 1'b1; hreason = HALT_VCATCH;
          end
          csr_n[SLOT_MCAUSE] = ecode;
          csr_n[SLOT_MTVAL]  = tval;
          trap_pend_n = 1'b1;
        end
        if (!stop) begin
          pc_n = npc;
          if (dbg_ctrl_q[1] && !hreq) begin
            hreq = 1'b1; hreason = HALT_STEP;
          end
        end
      end else if (s1_op_q == OP_LOAD && ld_valid_q) begin
        unique case (ld_f3_q)
          3'd0:    v = {{24{s1_ld_q[7]}}, s1_ld_q[7:0]};
          3'd1:    v = {{16{s1_ld_q[15]}}, s1_ld_q[15:0]};
          3'd4:    v = {24'd0, s1_ld_q[7:0]};
          3'd5:    v = {16'd0, s1_ld_q[15:0]};
          default: v = s1_ld_q;
        endcase
        rf_wr_n = '{we: ld_rd_q != 5'd0, addr: ld_rd_q, data: v};
        ld_valid_n = 1'b0;
        if (dbg_ctrl_q[1]) begin
          hreq = 1'b1; hreason = HALT_STEP;
        end
      end else if (s1_op_q == OP_IRQ) begin
        if ({1'b0, s1_irq_q} < 5'(FAST_IRQ_LINES)) begin
          if (dbg_ctrl_q[2]) begin
            hreq = 1'b1; hreason = HALT_VCATCH;
          end
          bitn = {1'b1, s1_irq_q};
          csr_n[SLOT_MCAUSE] = {1'b1, 26'd0, bitn};
          csr_n[SLOT_MIP][bitn] = 1'b1;
        end
      end

      // Trap entry at the end of the step, never while a load is outstanding.
      if (!ld_valid_n) begin
        if (trap_pend_n) begin
          trap_pend_n = 1'b0;
          found = 1'b1;
        end else if (csr_n[SLOT_MSTATUS][3]) begin
          for (int i = 0; i < FAST_IRQ_LINES; i++) begin
            if (!found && csr_n[SLOT_MIE][16 + i] && csr_n[SLOT_MIP][16 + i]) begin
              found = 1'b1;
              sel   = 4'(i);
            end
          end
          if (found) begin
            bitn = {1'b1, sel};
            csr_n[SLOT_MIP][bitn] = 1'b0;
            csr_n[SLOT_MCAUSE] = {1'b1, 26'd0, bitn};
          end
        end
        if (found) begin
          s = csr_n[SLOT_MSTATUS];
          s[7] = s[3];
          s[3] = 1'b0;
          s[12:11] = mode_n;
          csr_n[SLOT_MSTATUS] = s;
          mode_n = MODE_MACHINE;
          csr_n[SLOT_MEPC] = pc_n;
          pc_n = csr_n[SLOT_MTVEC];
          o_trap  = 1'b1;
          o_cause = csr_n[SLOT_MCAUSE][4:0];
          o_intr  = csr_n[SLOT_MCAUSE][31];
        end
      end
    end

    out_data_d = {2'd0, hreason, hreq, o_intr, o_cause, o_trap, o_sdata, o_msize,
                  o_maddr, o_mwrite, o_mvalid, pc_n};
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_op_q    <= s_axis_tuser;
      s1_ins_q   <= s_axis_tdata[31:0];
      s1_fault_q <= s_axis_tdata[32];
      s1_ld_q    <= s_axis_tdata[64:33];
      s1_irq_q   <= s_axis_tdata[68:65];
      fwd_a_q    <= rf_wr.we && rf_wr.addr == s_axis_tdata[19:15];
      fwd_b_q    <= rf_wr.we && rf_wr.addr == s_axis_tdata[24:20];
      fwd_data_q <= rf_wr.data;
    end
    if (s1_fire) begin
      out_data_q <= out_data_d;
      ld_rd_q    <= ld_rd_n;
      ld_f3_q    <= ld_f3_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pc_q        <= '0;
      mode_q      <= MODE_MACHINE;
      for (int i = 0; i < NUM_CSRS; i++) csr_q[i] <= '0;
      trap_pend_q <= 1'b0;
      ld_valid_q  <= 1'b0;
      dbg_ctrl_q  <= '0;
      dbg_halt_q  <= 1'b0;
    end else begin
      if (s_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        pc_q        <= pc_n;
        mode_q      <= mode_n;
        csr_q       <= csr_n;
        trap_pend_q <= trap_pend_n;
        ld_valid_q  <= ld_valid_n;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_DEBUG_CONTROL: dbg_ctrl_q <= cfg_data_i[2:0];
          CFG_DEBUG_HALTED:  dbg_halt_q <= cfg_data_i[0];
          CFG_RESET_PC:      pc_q       <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  `RVCM_ASSERT_SAME(a_no_x0_write, rf_wr.we, rf_wr.addr != 5'd0)
  `RVCM_ASSERT_NEXT(a_load_pending, s1_fire && out_data_d[32] && !out_data_d[33], ld_valid_q)
  `RVCM_ASSERT_NEXT(a_trap_machine, s1_fire && out_data_d[100], mode_q == MODE_MACHINE)
  `RVCM_ASSERT_SAME(a_no_trap_in_load, s1_fire && ld_valid_n, !out_data_d[100])

endmodule
`default_nettype wire
